// ===== hdl/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int STORE_BYTES_DEF   = 262144;
  localparam int GAMMA_ENTRIES_DEF = 1024;
  localparam int QUEUE_DEPTH       = 2;

  localparam int DIM_W      = 13;
  localparam int CH_W       = 3;
  localparam int FRAC_W     = 16;
  localparam int BADDR_W    = 18;
  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 32;
  localparam int COLOR_W    = 16;
  localparam int TIDX_W     = 2 * DIM_W;
  localparam int AIN_W      = 2 * DIM_W + CH_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 2'd2;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] tex_width;
    logic [DIM_W-1:0] tex_height;
    logic [CH_W-1:0]  channel_count;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [BADDR_W-1:0] addr;
    logic [BYTE_W-1:0]  value;
    logic [DIM_W-1:0]   x0;
    logic [DIM_W-1:0]   x1;
    logic [DIM_W-1:0]   y0;
    logic [DIM_W-1:0]   y1;
    logic [FRAC_W-1:0]  tx;
    logic [FRAC_W-1:0]  ty;
    logic [DIM_W-1:0]   w;
    logic [CH_W-1:0]    ch;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
  } result_t;

endpackage

// ===== hdl/bts_fifo.sv =====
// ----------------------------------------------------------------------------
// bts_fifo
// Small register queue that decouples two parts of the sampler.
// ----------------------------------------------------------------------------
module bts_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_nxt;
      if (do_pop) rd_ptr_r <= rd_ptr_nxt;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// ===== hdl/bts_front.sv =====
// ----------------------------------------------------------------------------
// bts_front
// Decodes input items: passes writes through, maps sample coordinates to
// the four neighbor texel positions and the blend weights.
// ----------------------------------------------------------------------------
module bts_front (
  input  logic                        in_push,
  input  logic                        in_cmd,
  input  logic [bts_pkg::BADDR_W-1:0] in_byte_addr,
  input  logic [bts_pkg::BYTE_W-1:0]  in_byte_value,
  input  logic [bts_pkg::COORD_W-1:0] in_u_coord,
  input  logic [bts_pkg::COORD_W-1:0] in_v_coord,
  input  bts_pkg::cfg_t               cfg,
  input  logic                        q_full,
  output logic                        q_push,
  output bts_pkg::item_t              q_item
);
  import bts_pkg::*;

  localparam int PW = FRAC_W + DIM_W;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [CH_W-1:0]  ch_eff;
  logic [PW-1:0]    pu, pv;
  logic [DIM_W:0]   x0p1, y0p1;

  always_comb begin
    w_eff  = (cfg.tex_width == '0) ? DIM_W'(1) : cfg.tex_width;
    h_eff  = (cfg.tex_height == '0) ? DIM_W'(1) : cfg.tex_height;
    ch_eff = (cfg.channel_count == '0) ? CH_W'(1) : cfg.channel_count;
    pu = PW'(in_u_coord[FRAC_W-1:0]) * PW'(w_eff - 1'b1);
    pv = PW'(in_v_coord[FRAC_W-1:0]) * PW'(h_eff - 1'b1);
    x0p1 = {1'b0, pu[PW-1:FRAC_W]} + 1'b1;
    y0p1 = {1'b0, pv[PW-1:FRAC_W]} + 1'b1;

    q_item.cmd   = in_cmd;
    q_item.addr  = in_byte_addr;
    q_item.value = in_byte_value;
    q_item.x0    = pu[PW-1:FRAC_W];
    q_item.y0    = pv[PW-1:FRAC_W];
    // wrap the +1 neighbor back to zero at the edge
    q_item.x1    = (x0p1 == {1'b0, w_eff}) ? '0 : x0p1[DIM_W-1:0];
    q_item.y1    = (y0p1 == {1'b0, h_eff}) ? '0 : y0p1[DIM_W-1:0];
    q_item.tx    = pu[FRAC_W-1:0];
    q_item.ty    = pv[FRAC_W-1:0];
    q_item.w     = w_eff;
    q_item.ch    = ch_eff;
  end

  assign q_push = in_push && !q_full;

endmodule

// ===== hdl/bts_back.sv =====
// ----------------------------------------------------------------------------
// bts_back
// Sequencer that owns the texel store and gamma table: performs writes,
// fetches the four neighbor texels, blends them and linearizes rgb.
// ----------------------------------------------------------------------------
module bts_back #(
  parameter int STORE_BYTES   = bts_pkg::STORE_BYTES_DEF,
  parameter int GAMMA_ENTRIES = bts_pkg::GAMMA_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  bts_pkg::item_t   q_item,
  output logic             q_pop,
  input  logic             res_full,
  output logic             res_push,
  output bts_pkg::result_t res
);
  import bts_pkg::*;

  // store size is a power of two: the low MA address bits are the wrap
  localparam int MA        = $clog2(STORE_BYTES);
  localparam int NB        = $clog2(GAMMA_ENTRIES + 1);
  localparam int MW        = FRAC_W + NB;

  typedef enum logic [3:0] {
    S_IDLE, S_TADDR, S_TSCALE, S_WRITE, S_RD,
    S_BLEND, S_GIDX, S_GLO, S_GHI, S_GMIX, S_PUSH
  } state_t;

  function automatic logic [15:0] gamma_entry(input logic [63:0] x);
    logic [63:0] lo, hi, mid, a, y;
    lo = '0;
    hi = 64'd1 << 30;
    for (int s = 0; s < 32; s++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        a = mid;
        for (int k = 0; k < 4; k++) a = (a * mid) >> 30;
        if (a <= x) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    y = (((x * x) >> 30) * lo) >> 30;
    return 16'((y * 64'd65535 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic logic [15:0] expand(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [CH_W-1:0] ch, input logic [1:0] k);
    logic [7:0] b;
    logic       opaque;
    b = b0;
    opaque = 1'b0;
    case (ch)
      3'd1: opaque = (k == 2'd3);
      3'd2: b = (k == 2'd3) ? b1 : b0;
      3'd3: begin
        opaque = (k == 2'd3);
        b = (k == 2'd1) ? b1 : (k == 2'd2) ? b2 : b0;
      end
      default: b = (k == 2'd1) ? b1 : (k == 2'd2) ? b2 : (k == 2'd3) ? b3 : b0;
    endcase
    return opaque ? 16'hFFFF : {b, b};
  endfunction

  // power 2.2 table, constant contents
  logic [15:0] gamma_rom [GAMMA_ENTRIES + 1];
  for (genvar gi = 0; gi <= GAMMA_ENTRIES; gi++) begin : g_rom
    localparam logic [63:0] GX = (64'(gi) << 30) / GAMMA_ENTRIES;
    assign gamma_rom[gi] = gamma_entry(GX);
  end

  logic [7:0] store_mem [STORE_BYTES];

  state_t            state_r;
  item_t             item_r;
  logic [1:0]        tex_r;
  logic [TIDX_W-1:0] tidx_r;
  logic [AIN_W-1:0]  mod_val_r;
  logic [2:0]        rd_cnt_r;
  logic [7:0]        rd_q_r;
  logic [7:0]        raw_r [4][4];
  logic [1:0]        bch_r, bop_r, gch_r;
  logic [15:0]       top_r, bot_r, lo_r, f_r, rom_q_r;
  logic [15:0]       col_r [4];
  logic [15:0]       lin_r [3];
  logic [NB-1:0]     k_r, rom_addr_r;

  logic [DIM_W-1:0]  cur_x, cur_y;
  logic [MA:0]       ba_sum;
  logic [MA-1:0]     mem_addr;
  logic              mem_we;
  logic [15:0]       mix_a, mix_b, mix_t, mix_res;
  logic signed [16:0] mix_d;
  logic signed [34:0] mix_p;
  logic [MW-1:0]     gm, gp;
  logic [NB-1:0]     gq0;
  logic [16:0]       gr;
  logic [15:0]       gcol;

  always_comb begin
    cur_x = tex_r[0] ? item_r.x1 : item_r.x0;
    cur_y = tex_r[1] ? item_r.y1 : item_r.y0;

    ba_sum = {1'b0, mod_val_r[MA-1:0]} + (MA+1)'(rd_cnt_r[1:0]);
    if (ba_sum >= (MA+1)'(STORE_BYTES)) ba_sum = ba_sum - (MA+1)'(STORE_BYTES);
    mem_we   = (state_r == S_WRITE);
    mem_addr = mem_we ? mod_val_r[MA-1:0] : ba_sum[MA-1:0];

    mix_a = '0;
    mix_b = '0;
    mix_t = '0;
    if (state_r == S_BLEND) begin
      case (bop_r)
        2'd0: begin
          mix_a = expand(raw_r[0][0], raw_r[0][1], raw_r[0][2], raw_r[0][3], item_r.ch, bch_r);
          mix_b = expand(raw_r[1][0], raw_r[1][1], raw_r[1][2], raw_r[1][3], item_r.ch, bch_r);
          mix_t = item_r.tx;
        end
        2'd1: begin
          mix_a = expand(raw_r[2][0], raw_r[2][1], raw_r[2][2], raw_r[2][3], item_r.ch, bch_r);
          mix_b = expand(raw_r[3][0], raw_r[3][1], raw_r[3][2], raw_r[3][3], item_r.ch, bch_r);
          mix_t = item_r.tx;
        end
        default: begin
          mix_a = top_r;
          mix_b = bot_r;
          mix_t = item_r.ty;
        end
      endcase
    end else if (state_r == S_GMIX) begin
      mix_a = lo_r;
      mix_b = rom_q_r;
      mix_t = f_r;
    end
    mix_d   = $signed({1'b0, mix_b}) - $signed({1'b0, mix_a});
    mix_p   = 35'(mix_d * $signed({1'b0, mix_t})) + 35'sd32768;
    mix_res = mix_a + 16'(mix_p >>> 16);

    // p = floor(c * N * 65536 / 65535) = m + floor(m / 65535), m = c * N
    gcol = col_r[gch_r];
    gm   = MW'(gcol) * MW'(GAMMA_ENTRIES);
    gq0  = gm[MW-1:FRAC_W];
    gr   = 17'(gm[FRAC_W-1:0]) + 17'(gq0);
    gp   = gm + MW'(gq0) + MW'(gr >= 17'd65535);
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_addr] <= item_r.value;
    else rd_q_r <= store_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    rom_q_r <= gamma_rom[rom_addr_r];
  end

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign res_push = (state_r == S_PUSH) && !res_full;
  assign res.red   = lin_r[0];
  assign res.green = lin_r[1];
  assign res.blue  = lin_r[2];
  assign res.alpha = col_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            item_r <= q_item;
            tex_r  <= '0;
            if (q_item.cmd == CMD_WRITE) begin
              mod_val_r <= AIN_W'(q_item.addr);
              state_r   <= S_WRITE;
            end else begin
              state_r <= S_TADDR;
            end
          end
        end
        S_TADDR: begin
          tidx_r  <= TIDX_W'(TIDX_W'(cur_y) * TIDX_W'(item_r.w)) + TIDX_W'(cur_x);
          state_r <= S_TSCALE;
        end
        S_TSCALE: begin
          mod_val_r <= AIN_W'(tidx_r) * AIN_W'(item_r.ch);
          rd_cnt_r  <= '0;
          state_r   <= S_RD;
        end
        S_WRITE: state_r <= S_IDLE;
        S_RD: begin
          if (rd_cnt_r != '0) raw_r[tex_r][2'(rd_cnt_r - 1'b1)] <= rd_q_r;
          rd_cnt_r <= rd_cnt_r + 1'b1;
          if (rd_cnt_r == 3'd4) begin
            if (tex_r == 2'd3) begin
              bch_r   <= '0;
              bop_r   <= '0;
              state_r <= S_BLEND;
            end else begin
              tex_r   <= tex_r + 1'b1;
              state_r <= S_TADDR;
            end
          end
        end
        S_BLEND: begin
          case (bop_r)
            2'd0:    top_r <= mix_res;
            2'd1:    bot_r <= mix_res;
            default: col_r[bch_r] <= mix_res;
          endcase
          if (bop_r == 2'd2) begin
            bop_r <= '0;
            if (bch_r == 2'd3) begin
              gch_r   <= '0;
              state_r <= S_GIDX;
            end else begin
              bch_r <= bch_r + 1'b1;
            end
          end else begin
            bop_r <= bop_r + 1'b1;
          end
        end
        S_GIDX: begin
          k_r        <= gp[MW-1:FRAC_W];
          f_r        <= gp[FRAC_W-1:0];
          rom_addr_r <= gp[MW-1:FRAC_W];
          state_r    <= S_GLO;
        end
        S_GLO: begin
          if (k_r != NB'(GAMMA_ENTRIES)) rom_addr_r <= k_r + 1'b1;
          state_r <= S_GHI;
        end
        S_GHI: begin
          lo_r    <= rom_q_r;
          state_r <= S_GMIX;
        end
        S_GMIX: begin
          lin_r[gch_r] <= (k_r == NB'(GAMMA_ENTRIES)) ? lo_r : mix_res;
          if (gch_r == 2'd2) begin
            state_r <= S_PUSH;
          end else begin
            gch_r   <= gch_r + 1'b1;
            state_r <= S_GIDX;
          end
        end
        S_PUSH: begin
          if (!res_full) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/bilinear_texture_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit
// Bilinear texture sampler with repeat wrap and power-2.2 gamma-to-linear output.
//
// Input items enter through push/full. cmd 0 writes byte_value into the
// texel store at byte_addr and yields no result; cmd 1 samples at u/v and
// yields one rgba result. Results leave through empty/pop, oldest first.
// A decode stage feeds a two-entry queue ahead of the sequencer, and the
// sequencer writes into a two-entry result queue, so input keeps flowing
// while a result waits; a stalled receiver backs up both queues to full.
// The sequencer finishes one item before it takes the next. A write takes
// the item, then writes its byte into the store. A sample takes the item,
// then per texel does an index multiply, a channel scale and its reads on
// the single byte port, then the blends, the three table lookups and the
// push into the result queue. The store size is a power of two, so the
// address wrap keeps the low bits.
// Reset empties both queues and sets width 1, height 1, four channels;
// the texel store is not cleared. Write configuration only while idle.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_unit #(
  parameter int STORE_BYTES   = bts_pkg::STORE_BYTES_DEF,
  parameter int GAMMA_ENTRIES = bts_pkg::GAMMA_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           full,
  input  logic                           in_cmd,
  input  logic [bts_pkg::BADDR_W-1:0]    in_byte_addr,
  input  logic [bts_pkg::BYTE_W-1:0]     in_byte_value,
  input  logic signed [bts_pkg::COORD_W-1:0] in_u_coord,
  input  logic signed [bts_pkg::COORD_W-1:0] in_v_coord,
  output logic                           empty,
  input  logic                           pop,
  output logic [bts_pkg::COLOR_W-1:0]    out_red,
  output logic [bts_pkg::COLOR_W-1:0]    out_green,
  output logic [bts_pkg::COLOR_W-1:0]    out_blue,
  output logic [bts_pkg::COLOR_W-1:0]    out_alpha,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bts_pkg::*;

  cfg_t    cfg_r;
  item_t   q_in, q_out;
  result_t res_in, res_out;
  logic    q_push, q_full, q_pop, q_empty;
  logic    res_push, res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tex_width     <= DIM_W'(1);
      cfg_r.tex_height    <= DIM_W'(1);
      cfg_r.channel_count <= CH_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEX_WIDTH:  cfg_r.tex_width     <= cfg_data[DIM_W-1:0];
        CFG_TEX_HEIGHT: cfg_r.tex_height    <= cfg_data[DIM_W-1:0];
        CFG_CHANNELS:   cfg_r.channel_count <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  bts_front u_front (
    .in_push       (in_push),
    .in_cmd        (in_cmd),
    .in_byte_addr  (in_byte_addr),
    .in_byte_value (in_byte_value),
    .in_u_coord    (in_u_coord),
    .in_v_coord    (in_v_coord),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  bts_fifo #(.W($bits(item_t)), .DEPTH(QUEUE_DEPTH)) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  bts_back #(.STORE_BYTES(STORE_BYTES), .GAMMA_ENTRIES(GAMMA_ENTRIES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_out),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  bts_fifo #(.W($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign full      = q_full;
  assign out_red   = res_out.red;
  assign out_green = res_out.green;
  assign out_blue  = res_out.blue;
  assign out_alpha = res_out.alpha;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full)) else $error("result pushed into full queue");

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("sequencer took item from empty queue");

  a_result_visible: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> !empty) else $error("pushed result not visible");

  a_push_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !q_full) |=> !q_empty) else $error("accepted item lost");

endmodule

// ===== dv/bilinear_texture_sampler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit_tb
// Self-checking testbench of the bilinear texture sampler. Texel bytes are
// written, then samples are taken under a range of texture sizes and
// channel counts. Every sample result is compared field by field against
// an in-bench model of the wrap, fetch, blend and power-2.2 table. Bytes a
// sample would touch are written first, so no unwritten texel is read.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_unit_tb;
  import bts_pkg::*;

  localparam int STORE   = STORE_BYTES_DEF;
  localparam int GAMMA_N = GAMMA_ENTRIES_DEF;
  localparam int LIMIT   = 4_000_000;
  localparam int SETTLE  = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  full;
  logic                  in_cmd = CMD_WRITE;
  logic [BADDR_W-1:0]    in_byte_addr = '0;
  logic [BYTE_W-1:0]     in_byte_value = '0;
  logic signed [COORD_W-1:0] in_u_coord = '0;
  logic signed [COORD_W-1:0] in_v_coord = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [COLOR_W-1:0]    out_red, out_green, out_blue, out_alpha;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bilinear_texture_sampler_unit dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .full(full), .in_cmd(in_cmd),
    .in_byte_addr(in_byte_addr), .in_byte_value(in_byte_value),
    .in_u_coord(in_u_coord), .in_v_coord(in_v_coord), .empty(empty), .pop(pop),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_alpha(out_alpha), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow state of the sampler
  bit [7:0]         texel_mirror [STORE];
  bit               texel_valid  [STORE];
  bit [15:0]        linear_lut   [GAMMA_N+1];
  bit [DIM_W-1:0]   tex_w = 13'd1, tex_h = 13'd1;
  bit [CH_W-1:0]    tex_ch = 3'd4;
  result_t          pending_colors [$];

  bit calm;
  int errors, samples_sent, writes_sent, colors_checked, cycles;

  function automatic bit [63:0] pow5_q30(bit [63:0] r);
    bit [63:0] a;
    a = r;
    for (int k = 0; k < 4; k++) a = (a * r) >> 30;
    return a;
  endfunction

  function automatic void build_lut();
    bit [63:0] x, lo, hi, mid, y;
    for (int i = 0; i <= GAMMA_N; i++) begin
      x = (64'(i) << 30) / GAMMA_N;
      lo = 0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (pow5_q30(mid) <= x) lo = mid;
        else hi = mid - 1;
      end
      y = (((x * x) >> 30) * lo) >> 30;
      linear_lut[i] = 16'((y * 65535 + (64'd1 << 29)) >> 30);
    end
  endfunction

  function automatic bit [63:0] blend(bit [63:0] a, bit [63:0] b, bit [63:0] t);
    return (a * (65536 - t) + b * t + 32768) >> 16;
  endfunction

  function automatic bit [15:0] to_linear(bit [63:0] c);
    bit [63:0] p, k;
    p = (c * GAMMA_N * 65536) / 65535;
    k = p >> 16;
    if (k >= GAMMA_N) return linear_lut[GAMMA_N];
    return 16'(blend(linear_lut[k], linear_lut[k+1], p & 16'hFFFF));
  endfunction

  // Byte bases of the four neighbours (00, 10, 01, 11) and the blend weights
  function automatic void neighbours(bit [31:0] u, bit [31:0] v,
                                     output bit [3:0][63:0] base,
                                     output bit [63:0] tx, output bit [63:0] ty);
    bit [63:0] w, h, ch, pu, pv, x0, x1, y0, y1;
    w  = (tex_w == 0) ? 1 : tex_w;
    h  = (tex_h == 0) ? 1 : tex_h;
    ch = (tex_ch == 0) ? 1 : tex_ch;
    pu = u[15:0] * (w - 1);
    pv = v[15:0] * (h - 1);
    x0 = pu >> 16;
    tx = pu & 16'hFFFF;
    y0 = pv >> 16;
    ty = pv & 16'hFFFF;
    x1 = (x0 + 1) % w;
    y1 = (y0 + 1) % h;
    base[0] = (y0 * w + x0) * ch;
    base[1] = (y0 * w + x1) * ch;
    base[2] = (y1 * w + x0) * ch;
    base[3] = (y1 * w + x1) * ch;
  endfunction

  function automatic bit [3:0][63:0] fetch_rgba(bit [63:0] base);
    bit [3:0][63:0] b, px;
    for (int j = 0; j < 4; j++) b[j] = texel_mirror[(base + j) % STORE] * 257;
    if (tex_ch >= 4) px = b;
    else if (tex_ch == 3) px = {64'd65535, b[2], b[1], b[0]};
    else if (tex_ch == 2) px = {b[1], b[0], b[0], b[0]};
    else px = {64'd65535, b[0], b[0], b[0]};
    return px;
  endfunction

  function automatic result_t filtered_color(bit [31:0] u, bit [31:0] v);
    bit [3:0][63:0] base, c00, c10, c01, c11, c;
    bit [63:0] tx, ty;
    result_t r;
    neighbours(u, v, base, tx, ty);
    c00 = fetch_rgba(base[0]);
    c10 = fetch_rgba(base[1]);
    c01 = fetch_rgba(base[2]);
    c11 = fetch_rgba(base[3]);
    for (int k = 0; k < 4; k++)
      c[k] = blend(blend(c00[k], c10[k], tx), blend(c01[k], c11[k], tx), ty);
    r.red   = to_linear(c[0]);
    r.green = to_linear(c[1]);
    r.blue  = to_linear(c[2]);
    r.alpha = 16'(c[3]);
    return r;
  endfunction

  task automatic send_item(logic cmd, bit [17:0] addr, bit [7:0] value,
                           bit [31:0] u, bit [31:0] v);
    in_cmd        = cmd;
    in_byte_addr  = addr;
    in_byte_value = value;
    in_u_coord    = u;
    in_v_coord    = v;
    in_push       = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if (cmd == CMD_WRITE) begin
      texel_mirror[addr] = value;
      texel_valid[addr]  = 1'b1;
      writes_sent++;
    end else begin
      pending_colors.insert(pending_colors.size(), filtered_color(u, v));
      samples_sent++;
    end
    @(negedge clk);
    // unless calm, idle each cycle with a fixed chance, so about a third of cycles idle
    while (!calm && $urandom_range(99) < 34) begin
      in_push = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic hold_input();
    in_push = 1'b0;
  endtask

  // Write every byte the sample will read that is not yet written, then issue it
  task automatic sample_at(bit [31:0] u, bit [31:0] v);
    bit [3:0][63:0] base;
    bit [63:0] tx, ty;
    bit [17:0] a;
    neighbours(u, v, base, tx, ty);
    for (int n = 0; n < 4; n++)
      for (int j = 0; j < 4; j++) begin
        a = 18'((base[n] + j) % STORE);
        if (!texel_valid[a]) send_item(CMD_WRITE, a, 8'($urandom), $urandom, $urandom);
      end
    send_item(CMD_SAMPLE, 18'($urandom), 8'($urandom), u, v);
  endtask

  task automatic drain();
    hold_input();
    while (pending_colors.size() != 0) @(negedge clk);
    // writes produce no result; let the last one finish
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, bit [12:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      CFG_TEX_WIDTH:  tex_w  = data;
      CFG_TEX_HEIGHT: tex_h  = data;
      CFG_CHANNELS:   tex_ch = data[2:0];
      default: ;
    endcase
  endtask

  task automatic configure(bit [12:0] w, bit [12:0] h, bit [12:0] ch);
    drain();
    set_reg(CFG_TEX_WIDTH, w);
    set_reg(CFG_TEX_HEIGHT, h);
    set_reg(CFG_CHANNELS, ch);
    set_reg(CFG_UNUSED, 13'($urandom));
  endtask

  function automatic bit [31:0] pick_coord();
    case ($urandom_range(7))
      0: return {16'($urandom_range(16'hFFFF)), 16'h0000};
      1: return {16'($urandom_range(16'hFFFF)), 16'hFFFF};
      2: return {16'($urandom_range(16'hFFFF)), 16'h8000};
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    if ($urandom_range(99) < 35)
      send_item(CMD_WRITE, 18'($urandom), 8'($urandom), $urandom, $urandom);
    else
      sample_at(pick_coord(), pick_coord());
  endtask

  task automatic test_directed();
    // default 1x1 rgba texture, byte extremes and the top store address
    send_item(CMD_WRITE, 18'd0, 8'd0, 0, 0);
    send_item(CMD_WRITE, 18'd1, 8'd255, 0, 0);
    send_item(CMD_WRITE, 18'd2, 8'd128, 0, 0);
    send_item(CMD_WRITE, 18'd3, 8'd255, 0, 0);
    send_item(CMD_WRITE, 18'h3FFFF, 8'd255, 0, 0);
    send_item(CMD_WRITE, 18'h3FFFF, 8'd0, 0, 0);
    sample_at(32'h0000_0000, 32'h0000_0000);
    sample_at(32'hFFFF_FFFF, 32'h8000_0000);
    sample_at(32'h7FFF_FFFF, 32'h8000_FFFF);
    // 2x2 grey at the midpoint and near the far edge, then grey+alpha, 3x2 rgb and 2x3 with zero channels
    configure(13'd2, 13'd2, 13'd1);
    sample_at(32'h0000_8000, 32'h0000_8000);
    sample_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    configure(13'd2, 13'd2, 13'd2);
    sample_at(32'h0000_8000, 32'h0001_4000);
    sample_at(32'h8000_C000, 32'h0000_0001);
    configure(13'd3, 13'd2, 13'd3);
    sample_at(32'h0000_AAAA, 32'h0000_5555);
    configure(13'd2, 13'd3, 13'd0);
    sample_at(32'h0000_8000, 32'hFFFF_8000);
  endtask

  task automatic test_corner_configs();
    bit [12:0] sizes [8][3] = '{'{13'd4096, 13'd4096, 13'd4}, '{13'd0, 13'd0, 13'd0},
                                '{13'd8191, 13'd8191, 13'd7}, '{13'd1, 13'd4096, 13'd1},
                                '{13'd4096, 13'd1, 13'd2}, '{13'd3, 13'd5, 13'd3},
                                '{13'd2, 13'd2, 13'd5}, '{13'd7, 13'd3, 13'd6}};
    int stop;
    for (int p = 0; p < 8; p++) begin
      configure(sizes[p][0], sizes[p][1], sizes[p][2]);
      stop = samples_sent + writes_sent + 60;
      while (samples_sent + writes_sent < stop) random_item();
    end
  endtask

  task automatic test_random();
    int stop;
    bit dried;
    for (int p = 0; p < 14; p++) begin
      configure(13'($urandom_range(1, 20)), 13'($urandom_range(1, 20)),
                13'($urandom_range(0, 7)));
      calm = (p == 5);
      stop = samples_sent + writes_sent + 80;
      dried = 1'b0;
      while (samples_sent + writes_sent < stop) begin
        // let the block run dry once, mid-phase
        if (p == 8 && !dried && samples_sent + writes_sent >= stop - 40) begin
          hold_input();
          while (pending_colors.size() != 0) @(negedge clk);
          dried = 1'b1;
        end
        random_item();
      end
      calm = 1'b0;
    end
  endtask

  // Result side: random pop, checked at the rising edge
  always @(negedge clk)
    pop <= calm ? 1'b1 : ($urandom_range(99) >= 34);

  task automatic check_field(string name, bit [15:0] exp_v, bit [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : color_check
    result_t want;
    if (rst_n && pop && !empty) begin
      if (pending_colors.size() == 0) begin
        $error("result item with no sample outstanding");
        errors++;
      end else begin
        want = pending_colors.pop_front();
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("alpha", want.alpha, out_alpha);
        colors_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout with %0d results outstanding", pending_colors.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    build_lut();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_corner_configs();
    test_random();
    drain();
    $display("covered %0d samples and %0d texel writes, %0d results compared,",
             samples_sent, writes_sent, colors_checked);
    $display("over sizes from 0 to 8191 and channel counts 0 to 7");
    if (errors == 0 && pending_colors.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bts_pkg.sv
hdl/bts_fifo.sv
hdl/bts_front.sv
hdl/bts_back.sv
hdl/bilinear_texture_sampler_unit.sv
dv/bilinear_texture_sampler_unit_tb.sv
